[rtl/core/sed_pkg.sv]
// sed_pkg: shared widths, status codes and character constants for the
// string escape decoder. No dependencies.
`default_nettype none

package sed_pkg;

  localparam int unsigned CharW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned NibW    = 4;

  typedef logic [CharW-1:0]   char_t;
  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [NibW-1:0]    nib_t;

  localparam status_t StOk         = 2'd0;
  localparam status_t StBadEscape  = 2'd1;
  localparam status_t StZeroEscape = 2'd2;
  localparam status_t StBadChar    = 2'd3;

  localparam char_t ChTab       = 16'h0009;
  localparam char_t ChLf        = 16'h000A;
  localparam char_t ChCr        = 16'h000D;
  localparam char_t ChBackslash = 16'h005C;
  localparam char_t ChN         = 16'h006E;
  localparam char_t ChR         = 16'h0072;
  localparam char_t ChT         = 16'h0074;
  localparam char_t ChX         = 16'h0078;
  localparam char_t ChSpace     = 16'h0020;
  localparam char_t ChTilde     = 16'h007E;

  typedef struct packed {
    logic ok;
    nib_t val;
  } hex_t;

  function automatic hex_t hex_value(input char_t c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = c[NibW-1:0];
    case (c) inside
      [16'h0030:16'h0039]: h.val = c[NibW-1:0];
      [16'h0041:16'h0046],
      [16'h0061:16'h0066]: h.val = c[NibW-1:0] + nib_t'(9);
      default:             h.ok  = 1'b0;
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

[rtl/core/sed_if.sv]
// sed_if: valid/ready channel interfaces for the decoder input and result
// items. Depends on sed_pkg.
`default_nettype none

interface sed_in_if;
  logic           valid;
  logic           ready;
  logic           kind;
  sed_pkg::char_t char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface sed_out_if;
  logic             valid;
  logic             ready;
  sed_pkg::byte_t   out_byte;
  logic             has_byte;
  logic             done_res;
  sed_pkg::status_t status;

  modport source (output valid, output out_byte, output has_byte, output done_res,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input done_res,
                  input status, output ready);
endinterface

`default_nettype wire

[rtl/core/string_escape_decoder_core.sv]
// string_escape_decoder_core: decodes a stream of 16-bit characters with
// C-style escapes into bytes. Depends on sed_pkg and sed_if.
//
//   channel   dir  payload                                   handshake
//   in_ch     in   kind, char_code                           valid/ready
//   out_ch    out  out_byte, has_byte, done_res, status      valid/ready
//
// One item per cycle unless out_ch stalls; a result appears in the cycle after its
// item is taken, from the result register. Items that give no result leave it untouched.
// in_ch.ready is high out of reset whenever the result register is empty or being taken.
// rst_n (synchronous) clears the escape mode, CR flag, error and result valid.
`default_nettype none

module string_escape_decoder_core (
  input  wire logic clk,
  input  wire logic rst_n,
  sed_in_if.sink    in_ch,
  sed_out_if.source out_ch
);

  localparam logic [1:0] ModeNormal = 2'd0;
  localparam logic [1:0] ModeEsc    = 2'd1;
  localparam logic [1:0] ModeHex1   = 2'd2;
  localparam logic [1:0] ModeHex2   = 2'd3;

  logic [1:0]       mode_r, mode_nxt;
  sed_pkg::nib_t    nib_r, nib_nxt;
  logic             cr_r, cr_nxt;
  sed_pkg::status_t err_r, err_nxt;

  logic             out_valid_r, out_valid_nxt;
  sed_pkg::byte_t   out_byte_r, out_byte_nxt;
  logic             has_byte_r, has_byte_nxt;
  logic             done_r, done_nxt;
  sed_pkg::status_t status_r, status_nxt;

  logic             in_fire;
  logic             res;
  sed_pkg::char_t   c;
  sed_pkg::hex_t    hx;
  sed_pkg::byte_t   hex_byte;

  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign c           = in_ch.char_code;
  assign hx          = sed_pkg::hex_value(c);
  assign hex_byte    = {nib_r, hx.val};

  always_comb begin
    mode_nxt     = mode_r;
    nib_nxt      = nib_r;
    cr_nxt       = cr_r;
    err_nxt      = err_r;
    res          = 1'b0;
    out_byte_nxt = out_byte_r;
    has_byte_nxt = has_byte_r;
    done_nxt     = done_r;
    status_nxt   = status_r;
    if (in_fire) begin
      if (in_ch.kind) begin
        res          = 1'b1;
        out_byte_nxt = '0;
        has_byte_nxt = 1'b0;
        done_nxt     = 1'b1;
        status_nxt   = (err_r == sed_pkg::StOk && mode_r != ModeNormal) ?
                       sed_pkg::StBadEscape : err_r;
        mode_nxt     = ModeNormal;
        nib_nxt      = '0;
        cr_nxt       = 1'b0;
        err_nxt      = sed_pkg::StOk;
      end else if (err_r == sed_pkg::StOk) begin
        cr_nxt       = 1'b0;
        has_byte_nxt = 1'b1;
        done_nxt     = 1'b0;
        status_nxt   = sed_pkg::StOk;
        out_byte_nxt = c[sed_pkg::ByteW-1:0];
        case (mode_r)
          ModeEsc: begin
            mode_nxt = ModeNormal;
            if (c == sed_pkg::ChN) begin
              res          = 1'b1;
              out_byte_nxt = sed_pkg::ChLf[sed_pkg::ByteW-1:0];
            end else if (c == sed_pkg::ChR) begin
              res          = 1'b1;
              out_byte_nxt = sed_pkg::ChCr[sed_pkg::ByteW-1:0];
            end else if (c == sed_pkg::ChT) begin
              res          = 1'b1;
              out_byte_nxt = sed_pkg::ChTab[sed_pkg::ByteW-1:0];
            end else if (c == sed_pkg::ChBackslash) begin
              res          = 1'b1;
              out_byte_nxt = sed_pkg::ChBackslash[sed_pkg::ByteW-1:0];
            end else if (c == sed_pkg::ChX) begin
              mode_nxt = ModeHex1;
            end else begin
              err_nxt = sed_pkg::StBadEscape;
            end
          end
          ModeHex1: begin
            if (!hx.ok) begin
              mode_nxt = ModeNormal;
              err_nxt  = sed_pkg::StBadEscape;
            end else begin
              nib_nxt  = hx.val;
              mode_nxt = ModeHex2;
            end
          end
          ModeHex2: begin
            mode_nxt = ModeNormal;
            if (!hx.ok) begin
              err_nxt = sed_pkg::StBadEscape;
            end else begin
              nib_nxt = '0;
              if (hex_byte == '0) begin
                err_nxt = sed_pkg::StZeroEscape;
              end else begin
                res          = 1'b1;
                out_byte_nxt = hex_byte;
              end
            end
          end
          default: begin
            if (c == sed_pkg::ChCr) begin
              cr_nxt       = 1'b1;
              res          = 1'b1;
              out_byte_nxt = sed_pkg::ChLf[sed_pkg::ByteW-1:0];
            end else if (c == sed_pkg::ChLf && cr_r) begin
              res = 1'b0;
            end else if (c == sed_pkg::ChBackslash) begin
              mode_nxt = ModeEsc;
            end else if (c > sed_pkg::ChTilde ||
                         (c < sed_pkg::ChSpace && c != sed_pkg::ChLf &&
                          c != sed_pkg::ChTab)) begin
              err_nxt = sed_pkg::StBadChar;
            end else begin
              res = 1'b1;
            end
          end
        endcase
      end
    end
    if (res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ModeNormal;
      nib_r       <= '0;
      cr_r        <= 1'b0;
      err_r       <= sed_pkg::StOk;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      nib_r       <= nib_nxt;
      cr_r        <= cr_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload loads only with a result
  always_ff @(posedge clk) begin
    if (res) begin
      out_byte_r <= out_byte_nxt;
      has_byte_r <= has_byte_nxt;
      done_r     <= done_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.has_byte = has_byte_r;
  assign out_ch.done_res = done_r;
  assign out_ch.status   = status_r;

endmodule

`default_nettype wire

[tb/sed_decode_checker.sv]
`timescale 1ns / 100ps
// sed_decode_checker: watches the decoder's input and result channels, predicts
// each result from the accepted items and compares it field by field.
// Depends on sed_pkg and the sed_in_if / sed_out_if interfaces.

module sed_decode_checker
  import sed_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sed_in_if           in_mon,
  sed_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned results_seen,
  output int unsigned ends_seen,
  output int unsigned bad_ends_seen
);

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeEsc    = 2'd1,
    ModeHex1   = 2'd2,
    ModeHex2   = 2'd3
  } esc_mode_t;

  typedef struct packed {
    byte_t   out_byte;
    logic    has_byte;
    logic    done_res;
    status_t status;
  } dec_result_t;

  esc_mode_t   mode;
  nib_t        hi_nib;
  logic        cr_seen;
  status_t     latched;
  dec_result_t pending_results[$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    results_seen  = 0;
    ends_seen     = 0;
    bad_ends_seen = 0;
  end

  task automatic report_error(input string msg);
    if (fail_count < 100) $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [4:0] hex_nibble(input char_t c);
    if (c >= 16'h0030 && c <= 16'h0039) return {1'b1, c[3:0]};
    if (c >= 16'h0061 && c <= 16'h0066) return {1'b1, nib_t'(c - 16'h0057)};
    if (c >= 16'h0041 && c <= 16'h0046) return {1'b1, nib_t'(c - 16'h0037)};
    return 5'd0;
  endfunction

  function automatic void predict_byte(input byte_t b);
    dec_result_t r;
    r          = '0;
    r.out_byte = b;
    r.has_byte = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic void clear_decoder();
    mode    = ModeNormal;
    hi_nib  = '0;
    cr_seen = 1'b0;
    latched = StOk;
  endfunction

  task automatic decode_item(input logic kind, input char_t c);
    logic        prev_cr;
    logic [4:0]  hd;
    byte_t       v;
    dec_result_t r;
    if (kind) begin
      r          = '0;
      r.done_res = 1'b1;
      r.status   = latched;
      if (latched == StOk && mode != ModeNormal) r.status = StBadEscape;
      clear_decoder();
      pending_results.push_back(r);
      return;
    end
    if (latched != StOk) return;
    prev_cr = cr_seen;
    cr_seen = 1'b0;
    case (mode)
      ModeEsc: begin
        mode = ModeNormal;
        if (c == ChN) predict_byte(8'h0A);
        else if (c == ChR) predict_byte(8'h0D);
        else if (c == ChT) predict_byte(8'h09);
        else if (c == ChBackslash) predict_byte(8'h5C);
        else if (c == ChX) mode = ModeHex1;
        else latched = StBadEscape;
        return;
      end
      ModeHex1: begin
        hd = hex_nibble(c);
        if (!hd[4]) begin
          mode    = ModeNormal;
          latched = StBadEscape;
        end else begin
          hi_nib = hd[3:0];
          mode   = ModeHex2;
        end
        return;
      end
      ModeHex2: begin
        hd   = hex_nibble(c);
        mode = ModeNormal;
        if (!hd[4]) begin
          latched = StBadEscape;
        end else begin
          v      = {hi_nib, hd[3:0]};
          hi_nib = '0;
          if (v == 8'h00) latched = StZeroEscape;
          else predict_byte(v);
        end
        return;
      end
      default: ;
    endcase
    if (c == ChCr) begin
      cr_seen = 1'b1;
      predict_byte(8'h0A);
    end else if (c == ChLf && prev_cr) begin
      // LF of a CR LF pair is dropped
    end else if (c == ChBackslash) begin
      mode = ModeEsc;
    end else if (c > ChTilde || (c < ChSpace && c != ChLf && c != ChTab)) begin
      latched = StBadChar;
    end else begin
      predict_byte(c[7:0]);
    end
  endtask

  task automatic check_result();
    dec_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result byte=%0h done=%0b with no item pending",
                             out_mon.out_byte, out_mon.done_res));
      return;
    end
    want = pending_results.pop_front();
    if (out_mon.out_byte !== want.out_byte)
      report_error($sformatf("result %0d out_byte %0h, expected %0h",
                             results_seen, out_mon.out_byte, want.out_byte));
    if (out_mon.has_byte !== want.has_byte)
      report_error($sformatf("result %0d has_byte %0b, expected %0b",
                             results_seen, out_mon.has_byte, want.has_byte));
    if (out_mon.done_res !== want.done_res)
      report_error($sformatf("result %0d done_res %0b, expected %0b",
                             results_seen, out_mon.done_res, want.done_res));
    if (out_mon.status !== want.status)
      report_error($sformatf("result %0d status %0d, expected %0d",
                             results_seen, out_mon.status, want.status));
    if (want.done_res) begin
      ends_seen++;
      if (want.status != StOk) bad_ends_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_decoder();
      pending_results.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) check_result();
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        decode_item(in_mon.kind, in_mon.char_code);
    end
    pending = pending_results.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// testbench: drives character strings with escapes and faults into
// string_escape_decoder_core under varying idle/stall phases and gives the verdict.
// Depends on sed_pkg, sed_if, the decoder core and sed_decode_checker.

module testbench;
  import sed_pkg::*;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned items_sent;
  int unsigned useful_items;
  int unsigned strings_sent;
  logic        in_error;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned ends_seen;
  int unsigned bad_ends_seen;

  sed_in_if  in_ch ();
  sed_out_if out_ch ();

  string_escape_decoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sed_decode_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .ends_seen     (ends_seen),
    .bad_ends_seen (bad_ends_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #5_000_000;
    $display("timeout: run did not drain, %0d results still expected", pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic k, input char_t c);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.kind      = k;
    in_ch.char_code = c;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    items_sent++;
    if (!in_error) useful_items++;
    @(negedge clk);
  endtask

  task automatic end_string();
    send_item(1'b1, char_t'($urandom));
    in_error = 1'b0;
    strings_sent++;
  endtask

  function automatic char_t hex_char(input nib_t v);
    if (v < 4'd10) return char_t'(16'h0030 + v);
    return char_t'(($urandom_range(1) ? 16'h0041 : 16'h0061) + v - 10);
  endfunction

  function automatic logic is_hex(input char_t c);
    return (c >= 16'h0030 && c <= 16'h0039) || (c >= 16'h0041 && c <= 16'h0046) ||
           (c >= 16'h0061 && c <= 16'h0066);
  endfunction

  function automatic char_t non_hex();
    char_t edges[5] = '{16'h002F, 16'h003A, 16'h0040, 16'h0047, 16'h0060};
    char_t c;
    case ($urandom_range(0, 3))
      0: c = char_t'($urandom);
      1: c = char_t'($urandom_range(16'h0067, 16'h007A));
      2: c = {8'($urandom_range(1, 255)), 8'(hex_char(nib_t'($urandom_range(0, 15))))};
      default: c = edges[$urandom_range(0, 4)];
    endcase
    if (is_hex(c)) c = 16'h0067;
    return c;
  endfunction

  task automatic send_token();
    int    pick;
    char_t c;
    byte_t v;
    char_t simple[4] = '{ChN, ChR, ChT, ChBackslash};
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c = char_t'($urandom_range(32, 126));
      send_item(1'b0, c);
      if (c == ChBackslash) send_item(1'b0, ChBackslash);
    end else if (pick < 52) begin
      send_item(1'b0, ChTab);
    end else if (pick < 58) begin
      send_item(1'b0, ChLf);
    end else if (pick < 66) begin
      send_item(1'b0, ChCr);
    end else if (pick < 72) begin
      send_item(1'b0, ChCr);
      send_item(1'b0, ChLf);
    end else if (pick < 82) begin
      send_item(1'b0, ChBackslash);
      send_item(1'b0, simple[$urandom_range(0, 3)]);
    end else if (pick < 97) begin
      v = 8'($urandom_range(1, 255));
      send_item(1'b0, ChBackslash);
      send_item(1'b0, ChX);
      send_item(1'b0, hex_char(v[7:4]));
      send_item(1'b0, hex_char(v[3:0]));
    end else begin
      // escaped CR does not swallow the LF
      send_item(1'b0, ChBackslash);
      send_item(1'b0, ChR);
      send_item(1'b0, ChLf);
    end
  endtask

  task automatic send_fault();
    char_t c;
    int    n;
    case ($urandom_range(0, 7))
      0: send_item(1'b0, char_t'($urandom));
      1: begin
        c = char_t'($urandom_range(0, 31));
        if (c == ChLf || c == ChTab || c == ChCr) c = 16'h0000;
        send_item(1'b0, c);
      end
      2: send_item(1'b0, char_t'($urandom_range(127, 65535)));
      3: begin
        c = char_t'($urandom);
        if (c == ChN || c == ChR || c == ChT || c == ChBackslash || c == ChX) c = 16'h0071;
        send_item(1'b0, ChBackslash);
        send_item(1'b0, c);
      end
      4: begin
        send_item(1'b0, ChBackslash);
        send_item(1'b0, ChX);
        send_item(1'b0, non_hex());
      end
      5: begin
        send_item(1'b0, ChBackslash);
        send_item(1'b0, ChX);
        send_item(1'b0, hex_char(nib_t'($urandom_range(0, 15))));
        send_item(1'b0, non_hex());
      end
      6: begin
        send_item(1'b0, ChBackslash);
        send_item(1'b0, ChX);
        send_item(1'b0, hex_char(4'h0));
        send_item(1'b0, hex_char(4'h0));
      end
      default: send_item(1'b0, {8'($urandom_range(1, 255)), 8'($urandom_range(32, 126))});
    endcase
    in_error = 1'b1;
    n = $urandom_range(0, 3);
    repeat (n) begin
      if ($urandom_range(1)) send_item(1'b0, char_t'($urandom));
      else send_item(1'b0, char_t'($urandom_range(32, 126)));
    end
  endtask

  task automatic send_open_escape();
    send_item(1'b0, ChBackslash);
    case ($urandom_range(0, 2))
      0: ;
      1: send_item(1'b0, ChX);
      default: begin
        send_item(1'b0, ChX);
        send_item(1'b0, hex_char(nib_t'($urandom_range(0, 15))));
      end
    endcase
  endtask

  task automatic random_string();
    int n;
    int fault_at;
    case ((useful_items / 150) % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 59; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 59; end
      default: begin idle_pct = 8; stall_pct = 8; end
    endcase
    n        = $urandom_range(0, 10);
    fault_at = ($urandom_range(99) < 25) ? $urandom_range(0, n) : n + 1;
    for (int i = 0; i < n; i++) begin
      if (i == fault_at) send_fault();
      else send_token();
    end
    if (fault_at == n) begin
      if ($urandom_range(1)) send_open_escape();
      else send_fault();
    end
    end_string();
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.kind      = 1'b0;
    in_ch.char_code = '0;
    out_ch.ready    = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    items_sent      = 0;
    useful_items    = 0;
    strings_sent    = 0;
    in_error        = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // empty string
    end_string();
    // printable extremes, raw TAB/LF, CR LF pair, escaped CR then LF, mixed-case hex
    send_item(1'b0, ChSpace);
    send_item(1'b0, ChTilde);
    send_item(1'b0, ChTab);
    send_item(1'b0, ChLf);
    send_item(1'b0, ChCr);
    send_item(1'b0, ChLf);
    send_item(1'b0, ChBackslash);
    send_item(1'b0, ChR);
    send_item(1'b0, ChLf);
    send_item(1'b0, ChBackslash);
    send_item(1'b0, ChX);
    send_item(1'b0, 16'h0061);
    send_item(1'b0, 16'h0046);
    end_string();
    // zero escape, then an ignored character
    send_item(1'b0, ChBackslash);
    send_item(1'b0, ChX);
    send_item(1'b0, 16'h0030);
    send_item(1'b0, 16'h0030);
    in_error = 1'b1;
    send_item(1'b0, 16'h0041);
    end_string();
    // unknown escape
    send_item(1'b0, ChBackslash);
    send_item(1'b0, 16'h0071);
    end_string();
    // widest bad character
    send_item(1'b0, 16'hFFFF);
    end_string();
    // escape left open at end
    send_item(1'b0, ChBackslash);
    end_string();

    while (items_sent < 1750) random_string();

    in_ch.valid = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d items in %0d strings across no-idle, sender-idle, receiver-stall",
             items_sent, strings_sent);
    $display("and mixed phases; %0d results checked, %0d of %0d strings ended in error.",
             results_seen, bad_ends_seen, ends_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
